### hdl/bsfd_pkg.sv
`default_nettype none

package bsfd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    // Escaped bytes come out with bit 5 flipped.
    localparam logic [BYTE_W-1:0] ESC_FLIP_MASK = 8'h20;

    localparam logic [BYTE_W-1:0] DELIM_RESET   = 8'd16;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET  = 8'd27;
    localparam logic              CHECK_RESET   = 1'b1;

    localparam logic [LEN_W-1:0]  LEN_MAX       = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE = 2'd2;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef struct packed {
        logic                 result_kind;
        logic [BYTE_W-1:0]    payload_byte;
        logic                 frame_good;
        logic [LEN_W-1:0]     frame_length;
        logic [COUNT_W-1:0]   good_frame_count;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_write;

endpackage

`default_nettype wire

### hdl/bsfd_in_if.sv
`default_nettype none

interface bsfd_in_if;
    logic                            valid;
    logic                            ready;
    logic [bsfd_pkg::BYTE_W-1:0]     rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### hdl/bsfd_out_if.sv
`default_nettype none

interface bsfd_out_if;
    logic                            valid;
    logic                            ready;
    logic                            result_kind;
    logic [bsfd_pkg::BYTE_W-1:0]     payload_byte;
    logic                            frame_good;
    logic [bsfd_pkg::LEN_W-1:0]      frame_length;
    logic [bsfd_pkg::COUNT_W-1:0]    good_frame_count;

    modport source (output valid, output result_kind, output payload_byte,
                    output frame_good, output frame_length,
                    output good_frame_count, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input frame_good, input frame_length,
                    input good_frame_count, output ready);
endinterface

`default_nettype wire

### hdl/bsfd_in_stage.sv
`default_nettype none

// Input register: holds one received byte until the decoder consumes it.
module bsfd_in_stage (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    bsfd_in_if.sink                          i_rx,
    input  wire logic                        i_advance,
    output logic                             o_valid,
    output logic [bsfd_pkg::BYTE_W-1:0]      o_byte
);

    logic                          r_valid;
    logic [bsfd_pkg::BYTE_W-1:0]   r_byte;
    logic                          n_valid;
    logic                          w_take;

    assign i_rx.ready = !r_valid || i_advance;
    assign w_take     = i_rx.valid && i_rx.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (w_take) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

### hdl/bsfd_core.sv
`default_nettype none

// Deframing state, configuration registers and the per-byte decode.
module bsfd_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bsfd_pkg::t_cfg_write        i_cfg,
    input  wire logic                        i_step,
    input  wire logic [bsfd_pkg::BYTE_W-1:0] i_byte,
    output logic                             o_res_valid,
    output bsfd_pkg::t_result                o_res
);

    logic [bsfd_pkg::BYTE_W-1:0]  r_delim, r_escape;
    logic                         r_check_en;
    logic                         r_in_frame, n_in_frame;
    logic                         r_esc_pend, n_esc_pend;
    logic [bsfd_pkg::BYTE_W-1:0]  r_xor, n_xor;
    logic [bsfd_pkg::LEN_W-1:0]   r_count, n_count;
    logic [bsfd_pkg::COUNT_W-1:0] r_good_cnt, n_good_cnt;
    logic                         w_good, w_take;
    logic [bsfd_pkg::BYTE_W-1:0]  w_data;

    always_comb begin
        n_in_frame  = r_in_frame;
        n_esc_pend  = r_esc_pend;
        n_xor       = r_xor;
        n_count     = r_count;
        n_good_cnt  = r_good_cnt;
        o_res_valid = 1'b0;
        w_take      = 1'b0;
        w_data      = i_byte;
        w_good      = (r_count != '0) && (r_xor == '0);
        o_res       = '0;

        if (i_step) begin
            if (!r_in_frame) begin
                if (i_byte == r_delim) begin
                    n_in_frame = 1'b1;
                    n_esc_pend = 1'b0;
                    n_xor      = '0;
                    n_count    = '0;
                end
            end else if (i_byte == r_delim) begin
                // Close: a pending escape is simply dropped.
                if (w_good && r_check_en) begin
                    n_good_cnt = r_good_cnt + 1'b1;
                end
                n_in_frame         = 1'b0;
                n_esc_pend         = 1'b0;
                n_xor              = '0;
                n_count            = '0;
                o_res_valid        = 1'b1;
                o_res.result_kind  = bsfd_pkg::KIND_END;
                o_res.frame_good   = w_good;
                o_res.frame_length = r_count;
            end else if (r_esc_pend) begin
                n_esc_pend = 1'b0;
                w_data     = i_byte ^ bsfd_pkg::ESC_FLIP_MASK;
                w_take     = 1'b1;
            end else if (i_byte == r_escape) begin
                n_esc_pend = 1'b1;
            end else begin
                w_take = 1'b1;
            end
        end

        if (w_take) begin
            n_xor = r_xor ^ w_data;
            if (r_count != bsfd_pkg::LEN_MAX) begin
                n_count = r_count + 1'b1;
            end
            o_res_valid        = 1'b1;
            o_res.result_kind  = bsfd_pkg::KIND_PAYLOAD;
            o_res.payload_byte = w_data;
        end
        o_res.good_frame_count = n_good_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim    <= bsfd_pkg::DELIM_RESET;
            r_escape   <= bsfd_pkg::ESCAPE_RESET;
            r_check_en <= bsfd_pkg::CHECK_RESET;
            r_in_frame <= 1'b0;
            r_esc_pend <= 1'b0;
            r_xor      <= '0;
            r_count    <= '0;
            r_good_cnt <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_esc_pend <= n_esc_pend;
            r_xor      <= n_xor;
            r_count    <= n_count;
            r_good_cnt <= n_good_cnt;
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    bsfd_pkg::REG_DELIMITER:    r_delim    <= i_cfg.wdata;
                    bsfd_pkg::REG_ESCAPE:       r_escape   <= i_cfg.wdata;
                    bsfd_pkg::REG_CHECK_ENABLE: r_check_en <= i_cfg.wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### hdl/bsfd_out_stage.sv
`default_nettype none

// Result register toward the downstream sink.
module bsfd_out_stage (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire logic                 i_res_valid,
    input  wire bsfd_pkg::t_result    i_res,
    output logic                      o_free,
    bsfd_out_if.source                o_res
);

    logic                 r_valid, n_valid;
    bsfd_pkg::t_result    r_res;

    assign o_free = !r_valid || o_res.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = i_res_valid;
        end else if (o_res.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid            = r_valid;
    assign o_res.result_kind      = r_res.result_kind;
    assign o_res.payload_byte     = r_res.payload_byte;
    assign o_res.frame_good       = r_res.frame_good;
    assign o_res.frame_length     = r_res.frame_length;
    assign o_res.good_frame_count = r_res.good_frame_count;

endmodule

`default_nettype wire

### hdl/byte_stuffed_frame_decoder_top.sv
// A received byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle, sustained, while the sink keeps ready high.
// The input register and the result register both advance on the same cycle,
// so the only limit is the sink; delimiters and escapes never stall the input.
// Reset is synchronous, active low: it clears the frame state, the good-frame
// count and both registers' valid flags, and restores the configuration defaults.
`default_nettype none

module byte_stuffed_frame_decoder_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bsfd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bsfd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    bsfd_in_if.sink                                i_rx,
    bsfd_out_if.source                             o_res
);

    // The input register holds the next byte; the core decodes it against the
    // frame state in the same cycle it moves on, and the result register
    // catches whatever result comes out. A byte moves on whenever the result
    // register is empty or being drained, even if it yields no result.
    logic                          w_stage_valid;
    logic [bsfd_pkg::BYTE_W-1:0]   w_stage_byte;
    logic                          w_out_free;
    logic                          w_advance;
    logic                          w_res_valid;
    bsfd_pkg::t_result             w_res;
    bsfd_pkg::t_cfg_write          w_cfg;

    assign w_advance = w_stage_valid && w_out_free;

    assign w_cfg.we    = i_cfg_we;
    assign w_cfg.idx   = i_cfg_idx;
    assign w_cfg.wdata = i_cfg_wdata;

    bsfd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (w_advance),
        .o_valid   (w_stage_valid),
        .o_byte    (w_stage_byte)
    );

    // Configuration and the frame state live in the core; the frame state only updates
    // when a byte actually moves out of the input register.
    bsfd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_step      (w_advance),
        .i_byte      (w_stage_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    bsfd_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_advance),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_free      (w_out_free),
        .o_res       (o_res)
    );

    // A payload result never carries end-of-frame status.
    a_payload_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.result_kind == bsfd_pkg::KIND_PAYLOAD)
            |-> (o_res.frame_length == '0 && !o_res.frame_good))
        else $error("payload result carries frame status");

    // A good frame is never empty.
    a_good_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_good) |-> (o_res.frame_length != '0))
        else $error("empty frame reported good");

    // No result can appear without a byte held in the input register.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_stage_valid && !o_res.valid) |=> !o_res.valid)
        else $error("result appeared without a request");

    // The good-frame count changes only at an end-of-frame result, so a payload
    // result carries the same count as the result loaded just before it.
    a_count_moves_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_advance && w_res.result_kind == bsfd_pkg::KIND_PAYLOAD
            && $past(w_res_valid && w_advance && i_rst_n))
            |-> (w_res.good_frame_count == o_res.good_frame_count))
        else $error("good-frame count moved on a payload byte");

endmodule

`default_nettype wire
